FILE: sv/row_batch_range_packer_macros.svh
// ---------------------------------------------------------------------------
// row batch range packer assertion macros
// shared concurrent assertion forms for the packer modules
// ---------------------------------------------------------------------------
`ifndef ROW_BATCH_RANGE_PACKER_MACROS_SVH
`define ROW_BATCH_RANGE_PACKER_MACROS_SVH

// same-cycle implication
`define RBRP_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBRP_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rbrp_pkg.sv
// ---------------------------------------------------------------------------
// rbrp_pkg
// types, constants and helpers shared by the row batch range packer
// ---------------------------------------------------------------------------
package rbrp_pkg;

  localparam int MAX_ROWS     = 65536;
  localparam int HEADER_BYTES = 4;

  localparam int SIZE_W   = 24;
  localparam int OFF_W    = 16;
  localparam int ROWS_W   = 17;
  localparam int BYTES_W  = 40;
  localparam int BUDGET_W = 32;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd1048576;

  // row index within a batch and row counts of a range
  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);

  // width of the five-times-bytes and four-times-budget merge compare
  localparam int CMP_W = BYTES_W + 3;

  localparam int EQ_DEPTH = 4;
  localparam int EQ_PTR_W = $clog2(EQ_DEPTH);
  localparam int EQ_CNT_W = $clog2(EQ_DEPTH + 1);

  typedef struct packed {
    logic [SIZE_W-1:0] row_size;
    logic              last_row;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0]   range_offset;
    logic [ROWS_W-1:0]  range_rows;
    logic [BYTES_W-1:0] range_bytes;
    logic [BYTES_W-1:0] batch_total_bytes;
    logic               last_range;
  } out_t;

  // per-row outcome handed from the front to the back
  typedef struct packed {
    logic               close_emit;
    logic [OFF_W-1:0]   c_start;
    logic [CNT_W-1:0]   c_rows;
    logic [BYTES_W-1:0] c_bytes;
    logic               is_end;
    logic               held_valid;
    logic [OFF_W-1:0]   h_start;
    logic [CNT_W-1:0]   h_rows;
    logic [BYTES_W-1:0] h_bytes;
    logic [OFF_W-1:0]   o_start;
    logic [CNT_W-1:0]   o_rows;
    logic [BYTES_W-1:0] o_bytes;
    logic [BYTES_W-1:0] total;
  } event_t;

  // record slots of one event, in output order
  typedef enum logic [1:0] {
    SLOT_DEFER,
    SLOT_CLOSE,
    SLOT_HELD,
    SLOT_OPEN
  } slot_t;

  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
  endfunction

endpackage

FILE: sv/row_batch_range_packer.sv
// ---------------------------------------------------------------------------
// row_batch_range_packer
// greedy packing of a batch's rows into byte-budgeted ranges
// ---------------------------------------------------------------------------
// usage:
//   rows enter on item with push/full; a row transfers when push is high and
//   full is low. ranges leave on result with empty/pop; the oldest range is
//   shown while empty is low and transfers when pop is high.
//   the byte budget is written on cfg_valid/cfg_ready/cfg_data; cfg_ready is
//   always high. write it only while no row is in flight.
// path: a range reaches the result port through the event queue and then
//   the result register, after the row that completes it transfers.
// throughput: one row per cycle while rows yield at most one range and the
//   result is popped; the back sequencer puts out one range per cycle while
//   its output is free, and the four-entry event queue absorbs two-range rows.
//   when a last row completes three ranges the third is given out just
//   ahead of the next row's ranges, once that row has been taken.
// reset: batch state clears, the budget returns to 1048576, nothing pending.
// a stalled receiver holds the result register; the event queue fills and
//   then full rises.
// ---------------------------------------------------------------------------
module row_batch_range_packer
  import rbrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  in_t                 item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output out_t                result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_data
);

  logic [BUDGET_W-1:0] budget;
  logic                ev_push;
  logic                ev_full;
  logic                ev_pop;
  logic                ev_empty;
  event_t              ev_in;
  event_t              ev_head;

  rbrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .budget    (budget),
    .ev_full   (ev_full),
    .ev_push   (ev_push),
    .ev        (ev_in)
  );

  rbrp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .wdata (ev_in),
    .full  (ev_full),
    .pop   (ev_pop),
    .rdata (ev_head),
    .empty (ev_empty)
  );

  rbrp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev_head),
    .ev_empty (ev_empty),
    .ev_pop   (ev_pop),
    .budget   (budget),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

FILE: sv/rbrp_queue.sv
// ---------------------------------------------------------------------------
// rbrp_queue
// short event queue between the front and the back
// ---------------------------------------------------------------------------
`include "row_batch_range_packer_macros.svh"

module rbrp_queue
  import rbrp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t wdata,
  output logic   full,
  input  logic   pop,
  output event_t rdata,
  output logic   empty
);

  event_t               mem [EQ_DEPTH];
  logic [EQ_PTR_W-1:0]  wr_ptr;
  logic [EQ_PTR_W-1:0]  rd_ptr;
  logic [EQ_CNT_W-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == EQ_CNT_W'(EQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RBRP_ASSERT_SAME(a_no_push_full, clk, rst, push, !full, "event pushed into full queue")
  `RBRP_ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1,
                    "queue count did not follow a lone push")

endmodule

FILE: sv/rbrp_front.sv
// ---------------------------------------------------------------------------
// rbrp_front
// accepts rows, tracks open and held ranges, classifies each row
// ---------------------------------------------------------------------------
`include "row_batch_range_packer_macros.svh"

module rbrp_front
  import rbrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  in_t                 item,
  output logic                full,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_data,
  output logic [BUDGET_W-1:0] budget,
  input  logic                ev_full,
  output logic                ev_push,
  output event_t              ev
);

  logic [RIDX_W-1:0]  row_index;
  logic [OFF_W-1:0]   open_start;
  logic [CNT_W-1:0]   open_rows;
  logic [BYTES_W-1:0] open_bytes;
  logic               held_valid;
  logic [OFF_W-1:0]   held_start;
  logic [CNT_W-1:0]   held_rows;
  logic [BYTES_W-1:0] held_bytes;
  logic [BYTES_W-1:0] total_bytes;

  logic               acc;
  logic               row_end;
  logic               close;
  logic [BYTES_W-1:0] cost;
  logic [BYTES_W:0]   ob_sum;
  logic [BYTES_W-1:0] total_next;
  logic [OFF_W-1:0]   open_start_next;
  logic [CNT_W-1:0]   open_rows_next;
  logic [BYTES_W-1:0] open_bytes_next;
  logic               held_valid_next;
  logic [OFF_W-1:0]   held_start_next;
  logic [CNT_W-1:0]   held_rows_next;
  logic [BYTES_W-1:0] held_bytes_next;

  assign full      = ev_full;
  assign cfg_ready = 1'b1;
  assign acc       = push && !ev_full;

  // a row that fills the batch ends it
  assign row_end = item.last_row || (row_index == RIDX_W'(MAX_ROWS - 1));
  assign cost    = BYTES_W'(item.row_size) + BYTES_W'(HEADER_BYTES);
  assign ob_sum  = {1'b0, open_bytes} + {1'b0, cost};
  assign close   = (open_rows != '0) && (ob_sum > (BYTES_W + 1)'(budget));

  assign total_next = sat_add(total_bytes, cost);

  always_comb begin
    if (close) begin
      held_valid_next = 1'b1;
      held_start_next = open_start;
      held_rows_next  = open_rows;
      held_bytes_next = open_bytes;
      open_start_next = OFF_W'(row_index);
      open_rows_next  = CNT_W'(1);
      open_bytes_next = cost;
    end else begin
      held_valid_next = held_valid;
      held_start_next = held_start;
      held_rows_next  = held_rows;
      held_bytes_next = held_bytes;
      open_start_next = (open_rows == '0) ? OFF_W'(row_index) : open_start;
      open_rows_next  = open_rows + 1'b1;
      open_bytes_next = ob_sum[BYTES_W] ? {BYTES_W{1'b1}} : ob_sum[BYTES_W-1:0];
    end
  end

  always_comb begin
    ev_push       = acc;
    ev.close_emit = close && held_valid;
    ev.c_start    = held_start;
    ev.c_rows     = held_rows;
    ev.c_bytes    = held_bytes;
    ev.is_end     = row_end;
    ev.held_valid = held_valid_next;
    ev.h_start    = held_start_next;
    ev.h_rows     = held_rows_next;
    ev.h_bytes    = held_bytes_next;
    ev.o_start    = open_start_next;
    ev.o_rows     = open_rows_next;
    ev.o_bytes    = open_bytes_next;
    ev.total      = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      budget <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      open_start  <= '0;
      open_rows   <= '0;
      open_bytes  <= '0;
      held_valid  <= 1'b0;
      held_start  <= '0;
      held_rows   <= '0;
      held_bytes  <= '0;
      total_bytes <= '0;
    end else if (acc) begin
      if (row_end) begin
        row_index   <= '0;
        open_start  <= '0;
        open_rows   <= '0;
        open_bytes  <= '0;
        held_valid  <= 1'b0;
        held_start  <= '0;
        held_rows   <= '0;
        held_bytes  <= '0;
        total_bytes <= '0;
      end else begin
        row_index   <= row_index + 1'b1;
        open_start  <= open_start_next;
        open_rows   <= open_rows_next;
        open_bytes  <= open_bytes_next;
        held_valid  <= held_valid_next;
        held_start  <= held_start_next;
        held_rows   <= held_rows_next;
        held_bytes  <= held_bytes_next;
        total_bytes <= total_next;
      end
    end
  end

  `RBRP_ASSERT_NEXT(a_batch_clears, clk, rst, acc && row_end,
                    (row_index == '0) && (open_rows == '0) && !held_valid,
                    "batch state not cleared after last row")

endmodule

FILE: sv/rbrp_back.sv
// ---------------------------------------------------------------------------
// rbrp_back
// walks each event's ranges, merges the tail, drives the result register
// ---------------------------------------------------------------------------
`include "row_batch_range_packer_macros.svh"

module rbrp_back
  import rbrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  event_t              ev,
  input  logic                ev_empty,
  output logic                ev_pop,
  input  logic [BUDGET_W-1:0] budget,
  output out_t                result,
  output logic                empty,
  input  logic                pop
);

  logic [1:0]   pos;
  logic [1:0]   k;
  logic         defer_valid;
  out_t         defer_rec;
  logic         out_valid;

  logic             hv;
  logic             merge;
  logic [CMP_W-1:0] o5;
  logic [CMP_W-1:0] b4;
  logic [3:0]       p;
  logic [3:0]       m;
  logic [3:0]       rest;
  slot_t            sel;
  logic             done;
  logic             third;
  logic             out_free;
  logic             advance;
  logic             emit_out;
  logic             defer_wr;
  out_t             rec;

  assign hv = !ev_empty;

  // final range merges when under four fifths of the budget
  assign o5    = {1'b0, ev.o_bytes, 2'b00} + CMP_W'(ev.o_bytes);
  assign b4    = CMP_W'({budget, 2'b00});
  assign merge = ev.held_valid && (o5 < b4);

  always_comb begin
    p             = '0;
    p[SLOT_DEFER] = defer_valid;
    p[SLOT_CLOSE] = ev.close_emit;
    p[SLOT_HELD]  = ev.is_end && ev.held_valid;
    p[SLOT_OPEN]  = ev.is_end && !merge;
  end

  assign m    = p & (4'b1111 << pos);
  assign rest = m & (m - 4'd1);
  assign done = (rest == '0);

  always_comb begin
    if (m[SLOT_DEFER]) begin
      sel = SLOT_DEFER;
    end else if (m[SLOT_CLOSE]) begin
      sel = SLOT_CLOSE;
    end else if (m[SLOT_HELD]) begin
      sel = SLOT_HELD;
    end else begin
      sel = SLOT_OPEN;
    end
  end

  always_comb begin
    rec.batch_total_bytes = ev.total;
    case (sel)
      SLOT_DEFER: begin
        rec = defer_rec;
      end
      SLOT_CLOSE: begin
        rec.range_offset = ev.c_start;
        rec.range_rows   = ROWS_W'(ev.c_rows);
        rec.range_bytes  = ev.c_bytes;
        rec.last_range   = 1'b0;
      end
      SLOT_HELD: begin
        rec.range_offset = ev.h_start;
        if (merge) begin
          rec.range_rows  = ROWS_W'(ev.h_rows + ev.o_rows);
          rec.range_bytes = sat_add(ev.h_bytes, ev.o_bytes);
          rec.last_range  = 1'b1;
        end else begin
          rec.range_rows  = ROWS_W'(ev.h_rows);
          rec.range_bytes = ev.h_bytes;
          rec.last_range  = 1'b0;
        end
      end
      default: begin
        rec.range_offset = ev.o_start;
        rec.range_rows   = ROWS_W'(ev.o_rows);
        rec.range_bytes  = ev.o_bytes;
        rec.last_range   = 1'b1;
      end
    endcase
  end

  // a third range of one row waits in the defer slot for the next row
  assign third    = (k == 2'd2);
  assign out_free = !out_valid || pop;
  assign advance  = hv && ((m == '0) || third || out_free);
  assign emit_out = hv && (m != '0) && !third && out_free;
  assign defer_wr = hv && (m != '0) && third;
  assign ev_pop   = advance && ((m == '0) || done);

  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      k           <= '0;
      defer_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        if (ev_pop) begin
          pos <= '0;
          k   <= '0;
        end else begin
          pos <= 2'(sel) + 2'd1;
          k   <= k + 2'd1;
        end
      end
      if (defer_wr) begin
        defer_valid <= 1'b1;
      end else if (advance && (m != '0) && (sel == SLOT_DEFER)) begin
        defer_valid <= 1'b0;
      end
      if (emit_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (defer_wr) begin
      defer_rec <= rec;
    end
    if (emit_out) begin
      result <= rec;
    end
  end

  `RBRP_ASSERT_SAME(a_defer_free, clk, rst, defer_wr, !defer_valid,
                    "deferred range overwritten before transfer")
  `RBRP_ASSERT_SAME(a_out_rise, clk, rst, $rose(out_valid), $past(emit_out),
                    "result appeared without an emission")

endmodule

FILE: bench/tb_row_batch_range_packer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_row_batch_range_packer
// self-checking bench: rows are pushed with random gaps, ranges popped with
// random stalls, and every popped range is compared against a local packing
// predictor that tracks the budget, the open and held ranges and the spill
// ---------------------------------------------------------------------------
module tb_row_batch_range_packer;
  import rbrp_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [63:0] BYTES_TOP = 64'hFF_FFFF_FFFF;

  logic                clk = 1'b0;
  logic                rst;
  logic                push;
  in_t                 item;
  logic                full;
  logic                empty;
  logic                pop;
  out_t                result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BUDGET_W-1:0] cfg_data;

  row_batch_range_packer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [BUDGET_W-1:0] pred_budget;
  logic [ROWS_W-1:0]   rows_in_batch;
  logic [OFF_W-1:0]    cur_first;
  logic [ROWS_W-1:0]   cur_rows;
  logic [BYTES_W-1:0]  cur_bytes;
  bit                  kept_valid;
  logic [OFF_W-1:0]    kept_first;
  logic [ROWS_W-1:0]   kept_rows;
  logic [BYTES_W-1:0]  kept_bytes;
  logic [BYTES_W-1:0]  batch_bytes;
  bit                  spill_valid;
  out_t                spill_range;
  out_t                ranges_due[$];

  int mismatches      = 0;
  int ranges_checked  = 0;
  int rows_taken      = 0;
  int merged_finals   = 0;
  int spilled_ranges  = 0;
  int budget_writes   = 0;
  int input_stalls    = 0;
  int quiet_cycles    = 0;

  // stimulus controls
  bit tx_gaps    = 1'b1;
  bit rx_steady  = 1'b0;
  bit rx_holding = 1'b0;
  int rx_hold_req = 0;

  function automatic logic [BYTES_W-1:0] clip_add(input logic [BYTES_W-1:0] a,
                                                  input logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > BYTES_TOP) ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
  endfunction

  function automatic out_t range_of(input logic [63:0] first, input logic [63:0] rows,
                                    input logic [63:0] bytes, input logic last);
    out_t o;
    o.range_offset      = first[OFF_W-1:0];
    o.range_rows        = rows[ROWS_W-1:0];
    o.range_bytes       = bytes[BYTES_W-1:0];
    o.batch_total_bytes = batch_bytes;
    o.last_range        = last;
    return o;
  endfunction

  function automatic void clear_batch();
    rows_in_batch = '0;
    cur_first     = '0;
    cur_rows      = '0;
    cur_bytes     = '0;
    kept_valid    = 1'b0;
    kept_first    = '0;
    kept_rows     = '0;
    kept_bytes    = '0;
    batch_bytes   = '0;
  endfunction

  // one accepted row: returns up to two ranges, a third waits for the next row
  function automatic void pack_row(input in_t r);
    out_t        found[$];
    logic [63:0] cost;
    bit          batch_end;
    cost      = 64'(r.row_size) + 64'(HEADER_BYTES);
    batch_end = r.last_row || (64'(rows_in_batch) + 64'd1 >= 64'(MAX_ROWS));
    if (spill_valid) begin
      found.insert(found.size(), spill_range);
      spill_valid = 1'b0;
    end
    batch_bytes = clip_add(batch_bytes, cost);
    if (cur_rows != 0 && 64'(cur_bytes) + cost > 64'(pred_budget)) begin
      if (kept_valid)
        found.insert(found.size(),
                     range_of(64'(kept_first), 64'(kept_rows), 64'(kept_bytes), 1'b0));
      kept_valid = 1'b1;
      kept_first = cur_first;
      kept_rows  = cur_rows;
      kept_bytes = cur_bytes;
      cur_rows   = '0;
      cur_bytes  = '0;
    end
    if (cur_rows == 0)
      cur_first = rows_in_batch[OFF_W-1:0];
    cur_bytes     = clip_add(cur_bytes, cost);
    cur_rows      = cur_rows + 1'b1;
    rows_in_batch = rows_in_batch + 1'b1;
    if (batch_end) begin
      // small final range folds into the held one
      if (kept_valid && 64'(cur_bytes) * 5 < 64'(pred_budget) * 4) begin
        found.insert(found.size(),
                     range_of(64'(kept_first), 64'(kept_rows) + 64'(cur_rows),
                              64'(clip_add(kept_bytes, 64'(cur_bytes))), 1'b1));
        merged_finals++;
      end else begin
        if (kept_valid)
          found.insert(found.size(),
                       range_of(64'(kept_first), 64'(kept_rows), 64'(kept_bytes), 1'b0));
        found.insert(found.size(),
                     range_of(64'(cur_first), 64'(cur_rows), 64'(cur_bytes), 1'b1));
      end
      clear_batch();
    end
    if (found.size() > 2) begin
      spill_range = found[2];
      spill_valid = 1'b1;
      spilled_ranges++;
    end
    for (int i = 0; i < found.size() && i < 2; i++)
      ranges_due.insert(ranges_due.size(), found[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at range %0d: %s got 0x%0h want 0x%0h",
               ranges_checked, what, got, want);
  endtask

  task automatic check_range(input out_t got);
    out_t want;
    if (ranges_due.size() == 0) begin
      report_mismatch("range with none due, offset", 64'(got.range_offset), 64'd0);
    end else begin
      want = ranges_due.pop_front();
      if (got.range_offset !== want.range_offset)
        report_mismatch("range_offset", 64'(got.range_offset), 64'(want.range_offset));
      if (got.range_rows !== want.range_rows)
        report_mismatch("range_rows", 64'(got.range_rows), 64'(want.range_rows));
      if (got.range_bytes !== want.range_bytes)
        report_mismatch("range_bytes", 64'(got.range_bytes), 64'(want.range_bytes));
      if (got.batch_total_bytes !== want.batch_total_bytes)
        report_mismatch("batch_total_bytes", 64'(got.batch_total_bytes),
                        64'(want.batch_total_bytes));
      if (got.last_range !== want.last_range)
        report_mismatch("last_range", 64'(got.last_range), 64'(want.last_range));
    end
    ranges_checked++;
  endtask

  // every transfer is seen here, in one place, at the edge where it happens
  always @(posedge clk) begin
    if (rst) begin
      pred_budget = BUDGET_RESET;
      clear_batch();
      spill_valid = 1'b0;
      ranges_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        pred_budget = cfg_data;
      if (push && full)
        input_stalls++;
      if (push && !full) begin
        pack_row(item);
        rows_taken++;
      end
      if (pop && !empty)
        check_range(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d ranges due",
               quiet_cycles, ranges_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, an optional long hold, or always ready
  initial begin
    int n;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        rx_holding = 1'b1;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
        rx_holding = 1'b0;
      end else if (rx_steady) begin
        pop <= 1'b1;
        @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        if (!rx_steady && rx_hold_req == 0) begin
          pop <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end
  end

  // leaves push high so back-to-back rows need no gap
  task automatic send_row(input logic [SIZE_W-1:0] size, input logic last);
    in_t r;
    r.row_size = size;
    r.last_row = last;
    push <= 1'b1;
    item <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (ranges_due.size() != 0) @(posedge clk);
    // a row may still be in flight even with nothing due
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    budget_writes++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(input logic [BUDGET_W-1:0] budget);
    logic [31:0] span;
    span = budget / 3;
    if (span > 32'h00FF_FFFF)
      span = 32'h00FF_FFFF;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom());
      default: return SIZE_W'($urandom_range(0, span));
    endcase
  endfunction

  task automatic test_directed();
    // reset budget, small tail merges into the held range
    send_row(24'd600000, 1'b0);
    send_row(24'd600000, 1'b1);
    write_budget(32'd100);
    send_row(24'd90, 1'b0);
    send_row(24'd10, 1'b1);
    // tail too big to merge
    send_row(24'd90, 1'b0);
    send_row(24'd80, 1'b1);
    // last row closes a range while one is held: three ranges at once
    send_row(24'd90, 1'b0);
    send_row(24'd90, 1'b0);
    send_row(24'd90, 1'b1);
    send_row(24'd0, 1'b1);
    // rows larger than the budget stand alone
    send_row(24'hFF_FFFF, 1'b0);
    send_row(24'hFF_FFFF, 1'b0);
    send_row(24'd0, 1'b1);
  endtask

  task automatic test_budget_extremes();
    write_budget(32'd0);
    send_row(24'd5, 1'b0);
    send_row(24'd0, 1'b0);
    send_row(24'd7, 1'b1);
    send_row(24'd3, 1'b1);
    write_budget(32'd1);
    send_row(24'd0, 1'b0);
    send_row(24'd0, 1'b0);
    send_row(24'd1, 1'b1);
    write_budget(32'hFFFF_FFFF);
    send_row(24'hFF_FFFF, 1'b0);
    send_row(24'hFF_FFFF, 1'b0);
    send_row(24'hFF_FFFF, 1'b0);
    send_row(24'd0, 1'b1);
  endtask

  // receiver holds off while rows keep coming until full rises
  task automatic test_backpressure();
    write_budget(32'd1);
    tx_gaps = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    wait (rx_holding);
    for (int k = 0; k < 60; k++)
      send_row(pick_size(32'd1000), k == 59);
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_batches();
    logic [BUDGET_W-1:0] budgets [6];
    int remaining;
    int n;
    budgets = '{32'd37, $urandom_range(64, 4096), BUDGET_RESET, $urandom(),
                32'hFFFF_FFFF, $urandom_range(5000, 200000)};
    for (int p = 0; p < 6; p++) begin
      // the closing phase runs with no idling on either side
      if (p == 5) begin
        tx_gaps   = 1'b0;
        rx_steady = 1'b1;
      end
      write_budget(budgets[p]);
      remaining = 300;
      while (remaining > 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
        if (n > remaining)
          n = remaining;
        for (int k = 0; k < n; k++)
          send_row(pick_size(budgets[p]), (k == n - 1) || ($urandom_range(0, 49) == 0));
        remaining -= n;
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_budget_extremes();
    test_backpressure();
    test_random_batches();
    wait_drained();

    if (ranges_due.size() != 0)
      report_mismatch("ranges never popped", 64'(ranges_due.size()), 64'd0);
    $display("summary: %0d rows, %0d ranges checked, %0d merged tails, %0d spilled ranges",
             rows_taken, ranges_checked, merged_finals, spilled_ranges);
    $display("summary: %0d budget writes, %0d cycles with a row stalled by full",
             budget_writes, input_stalls);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
